// File: sv/phk_pkg.sv
// shared types and constants for the position key hash pipeline
package phk_pkg;

	localparam int unsigned MAX_PITS      = 6;
	localparam int unsigned PIT_COUNT_DEF = 6;
	localparam int unsigned ELEM_W        = 8;
	localparam int unsigned FIELD_W       = 5;
	localparam int unsigned ROW_W         = MAX_PITS * ELEM_W;
	localparam int unsigned KEY_W         = MAX_PITS * FIELD_W;
	localparam int unsigned WORD_W        = 32;
	localparam int unsigned IDX_CFG_W     = 6;

	localparam logic [WORD_W-1:0]    GOLDEN_OFFSET  = 32'h9e37_79b9;
	localparam logic [WORD_W-1:0]    THIRD_INIT     = 32'hfca0_9587;
	localparam logic [IDX_CFG_W-1:0] INDEX_BITS_RST = 6'd20;

	// the three running words of the mix
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		logic [WORD_W-1:0] c;
	} mix_t;

	// control and key side-band that travels next to the mix words
	typedef struct packed {
		logic             ov;
		logic [KEY_W-1:0] ka;
		logic [KEY_W-1:0] kb;
	} keys_t;

endpackage

// File: sv/position_key_hash_core.sv
// top level of the position key hash: pack, range check and lookup2 mix in four stages
//
//  channel | signals                                   | direction | beat
//  --------+-------------------------------------------+-----------+--------------------------
//  in      | in_valid in_stall mover_side first_row    | sink      | in_valid & !in_stall
//          | second_row                                |           |
//  out     | out_valid out_stall overflow key_first    | source    | out_valid & !out_stall
//          | key_second table_index                    |           |
//  cfg     | cfg_we cfg_wdata (index_bits)             | sink      | cfg_we
//
// four register stages: pack/check/offset, mix lines 1-3, 4-6, 7-9 plus mask
// one beat per cycle sustained while out_stall is low; out_valid rises once the beat leaves stage 3
// each stage advances when it is empty or the stage after it advances, so bubbles collapse
// in_stall is high only while every stage holds a beat and out_stall is high
// reset clears the valid bits and sets index_bits to 20
module position_key_hash_core #(
	parameter int unsigned PIT_COUNT = phk_pkg::PIT_COUNT_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mover_side,
	input  logic [phk_pkg::ROW_W-1:0]     first_row,
	input  logic [phk_pkg::ROW_W-1:0]     second_row,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          overflow,
	output logic [phk_pkg::KEY_W-1:0]     key_first,
	output logic [phk_pkg::KEY_W-1:0]     key_second,
	output logic [phk_pkg::WORD_W-1:0]    table_index,
	input  logic                          cfg_we,
	input  logic [phk_pkg::IDX_CFG_W-1:0] cfg_wdata
);

	// configuration register
	logic [phk_pkg::IDX_CFG_W-1:0] index_bits_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q <= phk_pkg::INDEX_BITS_RST;
		end else if (cfg_we) begin
			index_bits_q <= cfg_wdata;
		end
	end

	// stage advance chain, computed from the output back
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4   = !out_valid || !out_stall;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) out_valid <= v_s3;
		end
	end

	// stage 1: pack both rows, range check, pick order, add golden offset
	logic [phk_pkg::KEY_W-1:0] key_r1, key_r2;
	logic                      ok_r1, ok_r2;
	phk_pkg::keys_t            keys_in, keys_s1, keys_s2, keys_s3;
	phk_pkg::mix_t             mix_in, mix_s1, mix_s2, mix_s3;
	phk_pkg::mix_t             mix_d2, mix_d3, mix_d4;

	phk_pack #(.PIT_COUNT(PIT_COUNT)) u_pack_first (
		.row(first_row),
		.key(key_r1),
		.ok (ok_r1)
	);

	phk_pack #(.PIT_COUNT(PIT_COUNT)) u_pack_second (
		.row(second_row),
		.key(key_r2),
		.ok (ok_r2)
	);

	always_comb begin
		keys_in.ov = !(ok_r1 && ok_r2);
		keys_in.ka = mover_side ? key_r1 : key_r2;
		keys_in.kb = mover_side ? key_r2 : key_r1;
		// keys are zero extended to the 32-bit mix words
		mix_in.a = phk_pkg::WORD_W'(keys_in.ka) + phk_pkg::GOLDEN_OFFSET;
		mix_in.b = phk_pkg::WORD_W'(keys_in.kb) + phk_pkg::GOLDEN_OFFSET;
		mix_in.c = phk_pkg::THIRD_INIT;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			keys_s1 <= keys_in;
			mix_s1  <= mix_in;
		end
	end

	// stages 2 to 4: three mix lines each
	phk_mix3 #(.SH_A(13), .SH_B(8),  .SH_C(13)) u_mix_s2 (.d(mix_s1), .q(mix_d2));
	phk_mix3 #(.SH_A(12), .SH_B(16), .SH_C(5))  u_mix_s3 (.d(mix_s2), .q(mix_d3));
	phk_mix3 #(.SH_A(3),  .SH_B(10), .SH_C(15)) u_mix_s4 (.d(mix_s3), .q(mix_d4));

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			keys_s2 <= keys_s1;
			mix_s2  <= mix_d2;
		end
		if (adv_s3) begin
			keys_s3 <= keys_s2;
			mix_s3  <= mix_d3;
		end
	end

	// index mask: widths of 32 and above keep every bit
	logic [phk_pkg::WORD_W-1:0] index_mask;

	assign index_mask = index_bits_q[phk_pkg::IDX_CFG_W-1]
		? '1 : ~({phk_pkg::WORD_W{1'b1}} << index_bits_q[phk_pkg::IDX_CFG_W-2:0]);

	// output register, overflow forces the payload to zero
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			overflow    <= keys_s3.ov;
			key_first   <= keys_s3.ov ? '0 : keys_s3.ka;
			key_second  <= keys_s3.ov ? '0 : keys_s3.kb;
			table_index <= keys_s3.ov ? '0 : (mix_d4.c & index_mask);
		end
	end

	// overflow beats carry an all-zero payload
	a_ov_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (key_first == '0 && key_second == '0 && table_index == '0))
		else $error("overflow beat with nonzero payload");

	// input is held off only when every stage is full and the output is stalled
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && out_valid && out_stall))
		else $error("input stalled with a free stage");

	// a beat in stage 1 that may advance reaches stage 2
	a_s1_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && adv_s2) |=> v_s2)
		else $error("beat lost between stage 1 and stage 2");

	// a stalled output beat is still there next cycle
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled output beat dropped");

endmodule

// File: sv/phk_pack.sv
// packs one row of byte counts into 5-bit fields and range checks it
module phk_pack #(
	parameter int unsigned PIT_COUNT = phk_pkg::PIT_COUNT_DEF
) (
	input  logic [phk_pkg::ROW_W-1:0] row,
	output logic [phk_pkg::KEY_W-1:0] key,
	output logic                      ok
);

	always_comb begin
		key = '0;
		ok  = 1'b1;
		for (int i = 0; i < PIT_COUNT; i++) begin
			// elements must stay in 0..31
			if (row[i*phk_pkg::ELEM_W+phk_pkg::FIELD_W +: phk_pkg::ELEM_W-phk_pkg::FIELD_W] != '0)
				ok = 1'b0;
			key[i*phk_pkg::FIELD_W +: phk_pkg::FIELD_W] = row[i*phk_pkg::ELEM_W +: phk_pkg::FIELD_W];
		end
	end

endmodule

// File: sv/phk_mix3.sv
// three lines of the lookup2 mix with their shift amounts
module phk_mix3 #(
	parameter int unsigned SH_A = 13,
	parameter int unsigned SH_B = 8,
	parameter int unsigned SH_C = 13
) (
	input  phk_pkg::mix_t d,
	output phk_pkg::mix_t q
);

	logic [phk_pkg::WORD_W-1:0] a1, b1, c1;

	always_comb begin
		a1 = (d.a - d.b - d.c) ^ (d.c >> SH_A);
		b1 = (d.b - d.c - a1) ^ (a1 << SH_B);
		c1 = (d.c - a1 - b1) ^ (b1 >> SH_C);
		q.a = a1;
		q.b = b1;
		q.c = c1;
	end

endmodule

// File: tb/tb_position_key_hash_core.sv
// self-checking testbench for position_key_hash_core: random positions, index widths and stalls
module tb_position_key_hash_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PITS        = phk_pkg::PIT_COUNT_DEF;
	localparam int HOLD_CYCLES = 200;
	localparam int IDLE_LIMIT  = 3000;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 130;
	localparam int REPORT_MAX  = 10;

	// one output beat as the block presents it
	typedef struct packed {
		logic                       ov;
		logic [phk_pkg::KEY_W-1:0]  kf;
		logic [phk_pkg::KEY_W-1:0]  ks;
		logic [phk_pkg::WORD_W-1:0] idx;
	} hash_result_t;

	// keeps its own copy of index_bits and the hashes still owed by the block
	class hash_result_book;
		logic [phk_pkg::IDX_CFG_W-1:0] index_bits;
		hash_result_t                  pending_hashes[$];
		int                            errors;

		function new();
			index_bits = phk_pkg::INDEX_BITS_RST;
			errors     = 0;
		endfunction

		// 5-bit packing, element 0 lowest; any set bit above bit 4 is out of range
		function bit pack_row(input logic [phk_pkg::ROW_W-1:0] row,
			output logic [phk_pkg::KEY_W-1:0] key);
			logic [phk_pkg::ELEM_W-1:0] elem;
			key = '0;
			for (int i = 0; i < PITS; i++) begin
				elem = row[phk_pkg::ELEM_W*i +: phk_pkg::ELEM_W];
				if (elem[phk_pkg::ELEM_W-1:phk_pkg::FIELD_W] != '0)
					return 1'b0;
				key[phk_pkg::FIELD_W*i +: phk_pkg::FIELD_W] = elem[phk_pkg::FIELD_W-1:0];
			end
			return 1'b1;
		endfunction

		// nine-line lookup2 mix, 32-bit wraparound
		function logic [phk_pkg::WORD_W-1:0] mix_keys(logic [phk_pkg::KEY_W-1:0] ka,
			logic [phk_pkg::KEY_W-1:0] kb);
			logic [phk_pkg::WORD_W-1:0] a;
			logic [phk_pkg::WORD_W-1:0] b;
			logic [phk_pkg::WORD_W-1:0] c;
			a = phk_pkg::WORD_W'(ka) + phk_pkg::GOLDEN_OFFSET;
			b = phk_pkg::WORD_W'(kb) + phk_pkg::GOLDEN_OFFSET;
			c = phk_pkg::THIRD_INIT;
			a = a - b; a = a - c; a = a ^ (c >> 13);
			b = b - c; b = b - a; b = b ^ (a << 8);
			c = c - a; c = c - b; c = c ^ (b >> 13);
			a = a - b; a = a - c; a = a ^ (c >> 12);
			b = b - c; b = b - a; b = b ^ (a << 16);
			c = c - a; c = c - b; c = c ^ (b >> 5);
			a = a - b; a = a - c; a = a ^ (c >> 3);
			b = b - c; b = b - a; b = b ^ (a << 10);
			c = c - a; c = c - b; c = c ^ (b >> 15);
			return c;
		endfunction

		// widths of 32 and above keep the whole word, zero keeps nothing
		function logic [phk_pkg::WORD_W-1:0] index_mask();
			logic [63:0] m;
			if (index_bits >= phk_pkg::IDX_CFG_W'(phk_pkg::WORD_W))
				return '1;
			m = (64'd1 << index_bits) - 64'd1;
			return m[phk_pkg::WORD_W-1:0];
		endfunction

		function void note_position(logic side, logic [phk_pkg::ROW_W-1:0] r1,
			logic [phk_pkg::ROW_W-1:0] r2);
			hash_result_t              want;
			logic [phk_pkg::KEY_W-1:0] k1;
			logic [phk_pkg::KEY_W-1:0] k2;
			bit                        ok1;
			bit                        ok2;
			ok1  = pack_row(r1, k1);
			ok2  = pack_row(r2, k2);
			want = '0;
			if (!ok1 || !ok2)
				want.ov = 1'b1;
			else begin
				want.kf  = side ? k1 : k2;
				want.ks  = side ? k2 : k1;
				want.idx = mix_keys(want.kf, want.ks) & index_mask();
			end
			pending_hashes.push_back(want);
		endfunction

		function void flag(string what, hash_result_t want, hash_result_t got);
			if (errors < REPORT_MAX)
				$display("%0t %0s: expected ov=%0b kf=%h ks=%h idx=%h, got ov=%0b kf=%h ks=%h idx=%h",
					$realtime, what, want.ov, want.kf, want.ks, want.idx,
					got.ov, got.kf, got.ks, got.idx);
			errors++;
		endfunction

		function void check_result(hash_result_t got);
			hash_result_t want;
			if (pending_hashes.size() == 0) begin
				flag("unexpected beat", '0, got);
				return;
			end
			want = pending_hashes.pop_front();
			if (got.ov !== want.ov || got.kf !== want.kf || got.ks !== want.ks ||
				got.idx !== want.idx)
				flag("mismatch", want, got);
		endfunction

		function int outstanding();
			return pending_hashes.size();
		endfunction

		function void close_out();
			while (pending_hashes.size() != 0)
				flag("missing beat", pending_hashes.pop_front(), '0);
		endfunction
	endclass

	logic                          clk        = 1'b0;
	logic                          arst_n     = 1'b0;
	logic                          in_valid   = 1'b0;
	logic                          in_stall;
	logic                          mover_side = 1'b0;
	logic [phk_pkg::ROW_W-1:0]     first_row  = '0;
	logic [phk_pkg::ROW_W-1:0]     second_row = '0;
	logic                          out_valid;
	logic                          out_stall  = 1'b0;
	logic                          overflow;
	logic [phk_pkg::KEY_W-1:0]     key_first;
	logic [phk_pkg::KEY_W-1:0]     key_second;
	logic [phk_pkg::WORD_W-1:0]    table_index;
	logic                          cfg_we     = 1'b0;
	logic [phk_pkg::IDX_CFG_W-1:0] cfg_wdata  = '0;

	hash_result_book book = new();

	// no random gaps on either side while set; a requested hold-off still happens
	bit quiet    = 1'b0;
	// asks the receiver for one long hold-off
	bit hold_req = 1'b0;
	int idle_cycles = 0;

	position_key_hash_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mover_side  (mover_side),
		.first_row   (first_row),
		.second_row  (second_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.overflow    (overflow),
		.key_first   (key_first),
		.key_second  (key_second),
		.table_index (table_index),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly no gap, some short, a few long
	function automatic int gap_len();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// monitor and watchdog: signals are read before this edge's updates land
	always @(posedge clk) begin
		hash_result_t seen;
		bit           moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				book.note_position(mover_side, first_row, second_row);
				moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				seen.ov  = overflow;
				seen.kf  = key_first;
				seen.ks  = key_second;
				seen.idx = table_index;
				book.check_result(seen);
				moved = 1'b1;
			end
			// a stretch with no beat on either side means the block hung
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_position_key_hash_core: errors");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && $urandom_range(0, 3) == 0)
				stall_left = gap_len();
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	// offer one position and hold it until the block takes the beat
	task automatic send_position(input logic side, input logic [phk_pkg::ROW_W-1:0] r1,
		input logic [phk_pkg::ROW_W-1:0] r2);
		in_valid   <= 1'b1;
		mover_side <= side;
		first_row  <= r1;
		second_row <= r2;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// sender goes quiet until every owed hash is back
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (book.outstanding() != 0)
			@(posedge clk);
	endtask

	// only called with the pipeline empty
	task automatic write_index_bits(input logic [phk_pkg::IDX_CFG_W-1:0] bits);
		cfg_we    <= 1'b1;
		cfg_wdata <= bits;
		@(posedge clk);
		cfg_we          <= 1'b0;
		book.index_bits = bits;
		@(posedge clk);
	endtask

	// in-range pits lean on the ends 0 and 31; a spoiled row gets a few bad bytes
	function automatic logic [phk_pkg::ROW_W-1:0] random_row(bit spoil);
		logic [phk_pkg::ROW_W-1:0] row;
		int                        r;
		for (int i = 0; i < phk_pkg::MAX_PITS; i++) begin
			r = $urandom_range(0, 9);
			row[phk_pkg::ELEM_W*i +: phk_pkg::ELEM_W] = (r == 0) ? 8'd0 : (r == 1) ? 8'd31 :
				phk_pkg::ELEM_W'($urandom_range(0, 31));
		end
		if (spoil)
			repeat ($urandom_range(1, 3))
				row[phk_pkg::ELEM_W*$urandom_range(0, phk_pkg::MAX_PITS-1) +: phk_pkg::ELEM_W] =
					phk_pkg::ELEM_W'($urandom_range(32, 255));
		return row;
	endfunction

	task automatic send_random_position();
		logic [phk_pkg::ROW_W-1:0] r1;
		logic [phk_pkg::ROW_W-1:0] r2;
		int                        kind;
		kind = $urandom_range(0, 99);
		if (kind < 5) begin
			// raw noise, nearly always out of range
			r1 = phk_pkg::ROW_W'({$urandom, $urandom});
			r2 = phk_pkg::ROW_W'({$urandom, $urandom});
		end else begin
			r1 = random_row(kind >= 75 && kind < 85 || kind >= 95);
			r2 = random_row(kind >= 85);
		end
		send_position($urandom_range(0, 1), r1, r2);
		pause_sender(gap_len());
	endtask

	// index widths walked by the phases: extremes, saturation and a random one
	function automatic logic [phk_pkg::IDX_CFG_W-1:0] phase_width(int p);
		case (p)
			0: return 6'd0;
			1: return 6'd1;
			2: return 6'd32;
			3: return 6'd63;
			4: return 6'd31;
			5: return 6'd33;
			6: return phk_pkg::IDX_CFG_W'($urandom_range(2, 30));
			default: return phk_pkg::INDEX_BITS_RST;
		endcase
	endfunction

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed beats at the reset width, back to back
		send_position(1'b0, '0, '0);
		send_position(1'b1, '0, '0);
		send_position(1'b1, 48'h1f1f_1f1f_1f1f, 48'h1f1f_1f1f_1f1f);
		send_position(1'b0, 48'h1f1f_1f1f_1f1f, 48'h0000_0000_0000);
		// distinct rows with both sides shows the swap
		send_position(1'b1, 48'h0504_0302_0100, 48'h1a1b_1c1d_1e1f);
		send_position(1'b0, 48'h0504_0302_0100, 48'h1a1b_1c1d_1e1f);
		send_position(1'b1, 48'h1008_0402_0110, 48'h0110_0804_0201);
		send_position(1'b0, 48'h0101_0101_0101, 48'h1010_1010_1010);
		// overflow: just past 31, negative counts, largest positive byte, both rows bad
		send_position(1'b1, 48'h0000_0000_0020, 48'h0000_0000_0000);
		send_position(1'b0, 48'h0000_0000_0000, 48'hff00_0000_0000);
		send_position(1'b1, 48'h0000_8000_0000, 48'h1f1f_1f1f_1f1f);
		send_position(1'b0, 48'h7f00_0000_0000, 48'h0000_0000_0000);
		send_position(1'b1, 48'h1f1f_1f1f_1f1f, 48'h1f1f_1f40_1f1f);
		send_position(1'b1, 48'hffff_ffff_ffff, 48'hffff_ffff_ffff);

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			write_index_bits(phase_width(p));
			// phase 2 holds the receiver off while beats keep coming, so the block backs up
			quiet = (p == 2 || p == 4);
			if (p == 2)
				hold_req = 1'b1;
			repeat (PHASE_BEATS) send_random_position();
		end

		drain_results();
		quiet = 1'b0;
		// wait past the pipeline depth to catch stray beats
		repeat (8) @(posedge clk);
		book.close_out();
		if (book.errors == 0)
			$display("tb_position_key_hash_core: clean");
		else
			$display("tb_position_key_hash_core: errors");
		$finish;
	end

endmodule

// File: files.f
sv/phk_pkg.sv
sv/phk_pack.sv
sv/phk_mix3.sv
sv/position_key_hash_core.sv
tb/tb_position_key_hash_core.sv
